FILE: rtl/vector_table_engine_macros.svh
// Assertion macros used by the vector table engine RTL.
`ifndef VECTOR_TABLE_ENGINE_MACROS_SVH
`define VECTOR_TABLE_ENGINE_MACROS_SVH
// Checks that an antecedent implies a consequent in the same cycle.
`define VTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// Checks that an antecedent implies a consequent in the next cycle.
`define VTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

FILE: rtl/vte_pkg.sv
// ----------------------------------------------------------------------------
// vte_pkg
// Shared types and constants of the vector table engine.
// ----------------------------------------------------------------------------
package vte_pkg;
	localparam int Capacity  = 1024;
	localparam int ElemWidth = 32;
	localparam int AddrW     = $clog2(Capacity);
	localparam int CountW    = $clog2(Capacity + 1);

	typedef logic [3:0] func_t;
	localparam func_t FuncPush     = 4'd0;
	localparam func_t FuncPop      = 4'd1;
	localparam func_t FuncClear    = 4'd2;
	localparam func_t FuncContains = 4'd3;
	localparam func_t FuncIndexOf  = 4'd4;
	localparam func_t FuncSortAsc  = 4'd5;
	localparam func_t FuncSortDesc = 4'd6;
	localparam func_t FuncReverse  = 4'd7;
	localparam func_t FuncDedup    = 4'd8;

	typedef enum logic [3:0] {
		StIdle,
		StSearchRd,
		StSearchCmp,
		StSortRdCur,
		StSortRdPrev,
		StSortCmp,
		StRevRdLo,
		StRevRdHi,
		StRevSwap,
		StDedupRd,
		StDedupCand,
		StDedupCmp,
		StPopRd,
		StDone
	} state_t;
endpackage

FILE: rtl/vector_table_engine.sv
// Push and clear go straight to the done state, and pop reads the top entry first;
// search, reverse, dedup and the insertion sort step through the entries one
// memory access at a time, as the single-port entry memory allows.
// One word is processed at a time; ready is low while a word is at work, and a
// finished result waits in its own register. arst_n clears count and control.
// ----------------------------------------------------------------------------
// vector_table_engine
// Bounded stack of signed entries with search, sort, reverse and dedup.
// ----------------------------------------------------------------------------
`include "vector_table_engine_macros.svh"
module vector_table_engine import vte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         func,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] popped_value,
	output logic               found,
	output logic signed [10:0] found_index,
	output logic [10:0]        entry_count,
	output logic               full_or_empty
);
	// The entry memory: one port, written or read once a cycle.
	logic [ElemWidth-1:0] mem [Capacity];
	logic [ElemWidth-1:0] rd_data_q;

	state_t state_q, state_d;
	logic [CountW-1:0] count_q, count_d;
	logic [CountW-1:0] i_q, i_d, j_q, j_d;
	logic [ElemWidth-1:0] cur_q, cur_d, tmp_q, tmp_d;
	logic [3:0] func_q, func_d;
	logic [ElemWidth-1:0] key_q, key_d;
	logic desc_q, desc_d;
	logic [31:0] pop_q, pop_d;
	logic found_q, found_d, flag_q, flag_d;
	logic [10:0] idx_q, idx_d;
	logic out_valid_q, out_valid_d;

	// The finished result is held here so the next word can start meanwhile.
	logic [31:0] res_pop_q;
	logic        res_found_q;
	logic [10:0] res_idx_q;
	logic [10:0] res_count_q;
	logic        res_flag_q;
	logic        res_load;

	logic mem_we;
	logic [AddrW-1:0] mem_addr;
	logic [ElemWidth-1:0] mem_wdata;

	logic in_fire;
	logic out_fire;
	logic cur_before;
	logic [ElemWidth-1:0] key_ord, mem_ord;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign in_ready = (state_q == StIdle);
	assign res_load = (state_q == StDone) && (!out_valid_q || out_fire);

	// Flip the sign bits so that unsigned compare gives signed order.
	assign key_ord = cur_q ^ {1'b1, {(ElemWidth-1){1'b0}}};
	assign mem_ord = rd_data_q ^ {1'b1, {(ElemWidth-1){1'b0}}};
	assign cur_before = desc_q ? (key_ord > mem_ord) : (key_ord < mem_ord);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q     <= i_d;
		j_q     <= j_d;
		cur_q   <= cur_d;
		tmp_q   <= tmp_d;
		func_q  <= func_d;
		key_q   <= key_d;
		desc_q  <= desc_d;
		pop_q   <= pop_d;
		found_q <= found_d;
		flag_q  <= flag_d;
		idx_q   <= idx_d;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_pop_q   <= pop_q;
			res_found_q <= found_q;
			res_idx_q   <= idx_q;
			res_count_q <= 11'(count_q);
			res_flag_q  <= flag_q;
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		i_d         = i_q;
		j_d         = j_q;
		cur_d       = cur_q;
		tmp_d       = tmp_q;
		func_d      = func_q;
		key_d       = key_q;
		desc_d      = desc_q;
		pop_d       = pop_q;
		found_d     = found_q;
		flag_d      = flag_q;
		idx_d       = idx_q;
		out_valid_d = out_valid_q;
		mem_we      = 1'b0;
		mem_addr    = i_q[AddrW-1:0];
		mem_wdata   = cur_q;
		if (out_fire) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			StIdle: begin
				if (in_fire) begin
					func_d  = func;
					key_d   = value[ElemWidth-1:0];
					pop_d   = '0;
					found_d = 1'b0;
					flag_d  = 1'b0;
					idx_d   = '1;
					i_d     = '0;
					desc_d  = (func == FuncSortDesc);
					state_d = StDone;
					priority case (func)
						FuncPush: begin
							if (count_q == CountW'(Capacity)) begin
								flag_d = 1'b1;
							end else begin
								mem_we    = 1'b1;
								mem_addr  = count_q[AddrW-1:0];
								mem_wdata = value[ElemWidth-1:0];
								count_d   = count_q + 1'b1;
							end
						end
						FuncPop: begin
							if (count_q == '0) begin
								flag_d = 1'b1;
							end else begin
								count_d  = count_q - 1'b1;
								mem_addr = AddrW'(count_q - 1'b1);
								state_d  = StPopRd;
							end
						end
						FuncClear: count_d = '0;
						FuncContains, FuncIndexOf: state_d = StSearchRd;
						FuncSortAsc, FuncSortDesc: begin
							i_d     = CountW'(1);
							state_d = StSortRdCur;
						end
						FuncReverse: begin
							j_d     = count_q - 1'b1;
							state_d = (count_q > CountW'(1)) ? StRevRdLo : StDone;
						end
						FuncDedup: begin
							i_d     = CountW'(1);
							j_d     = CountW'(1);
							state_d = (count_q > CountW'(1)) ? StDedupRd : StDone;
						end
						default: state_d = StDone;
					endcase
				end
			end
			// The top entry was read at the accepting edge.
			StPopRd: begin
				pop_d   = 32'(signed'(rd_data_q));
				state_d = StDone;
			end
			StSearchRd: begin
				if (i_q >= count_q) begin
					state_d = StDone;
				end else begin
					state_d = StSearchCmp;
				end
			end
			StSearchCmp: begin
				if (rd_data_q == key_q) begin
					found_d = 1'b1;
					idx_d   = 11'(i_q);
					state_d = StDone;
				end else begin
					i_d      = i_q + 1'b1;
					mem_addr = AddrW'(i_q + 1'b1);
					state_d  = StSearchRd;
				end
			end
			// Insertion sort: cur_q is the element being placed, j_q the hole.
			StSortRdCur: begin
				if (i_q >= count_q) begin
					state_d = StDone;
				end else begin
					j_d     = i_q;
					state_d = StSortRdPrev;
				end
			end
			StSortRdPrev: begin
				if (j_q == i_q) begin
					cur_d = rd_data_q;
				end
				if (j_q == '0) begin
					state_d = StSortCmp;
				end else begin
					mem_addr = AddrW'(j_q - 1'b1);
					state_d  = StSortCmp;
				end
			end
			StSortCmp: begin
				mem_we   = 1'b1;
				mem_addr = j_q[AddrW-1:0];
				if (j_q != '0 && cur_before) begin
					mem_wdata = rd_data_q;
					j_d       = j_q - 1'b1;
					state_d   = StSortRdPrev;
				end else begin
					mem_wdata = cur_q;
					i_d       = i_q + 1'b1;
					state_d   = StSortRdCur;
				end
			end
			// Reverse: read low, read high, then write both.
			StRevRdLo: begin
				if (i_q >= j_q) begin
					state_d = StDone;
				end else begin
					state_d = StRevRdHi;
				end
			end
			StRevRdHi: begin
				tmp_d    = rd_data_q;
				mem_addr = j_q[AddrW-1:0];
				state_d  = StRevSwap;
			end
			StRevSwap: begin
				mem_we    = 1'b1;
				mem_addr  = i_q[AddrW-1:0];
				mem_wdata = rd_data_q;
				cur_d     = tmp_q;
				tmp_d     = tmp_q;
				state_d   = StDedupCmp;
			end
			// Dedup: read the candidate at i_q, then the last kept entry.
			StDedupRd: begin
				if (i_q >= count_q) begin
					count_d = j_q;
					state_d = StDone;
				end else begin
					state_d = StDedupCand;
				end
			end
			StDedupCand: begin
				tmp_d    = rd_data_q;
				mem_addr = AddrW'(j_q - 1'b1);
				state_d  = StDedupCmp;
			end
			StDedupCmp: begin
				if (func_q == FuncReverse) begin
					mem_we    = 1'b1;
					mem_addr  = j_q[AddrW-1:0];
					mem_wdata = cur_q;
					i_d       = i_q + 1'b1;
					j_d       = j_q - 1'b1;
					mem_addr  = j_q[AddrW-1:0];
					state_d   = StRevRdLo;
				end else begin
					// rd_data_q holds the last kept entry; tmp_q the candidate.
					if (tmp_q != rd_data_q) begin
						mem_we    = 1'b1;
						mem_addr  = j_q[AddrW-1:0];
						mem_wdata = tmp_q;
						j_d       = j_q + 1'b1;
					end
					i_d     = i_q + 1'b1;
					state_d = StDedupRd;
				end
			end
			StDone: begin
				if (res_load) begin
					out_valid_d = 1'b1;
					state_d     = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign popped_value  = res_pop_q;
	assign found         = res_found_q;
	assign found_index   = res_idx_q;
	assign entry_count   = res_count_q;
	assign full_or_empty = res_flag_q;

	`VTE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CountW'(Capacity), "count above capacity")
	`VTE_ASSERT_IMP(a_ready_idle, in_ready, state_q == StIdle, "ready while busy")
	`VTE_ASSERT_IMP(a_found_idx, out_valid_q && !res_found_q, res_idx_q == '1, "index without hit")
	`VTE_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q && $stable(res_pop_q), "result dropped")
endmodule
